>>> src/fcal_pkg.sv
// ----------------------------------------------------------------------------
// fcal_pkg - shared definitions for the fixed-capacity array list
// Operation modes, status codes, cell commands and the command bundle that
// the control logic broadcasts to the element cells.
// ----------------------------------------------------------------------------
package fcal_pkg;

    localparam int CNT_W   = 7;
    localparam int POS2_W  = 6;
    localparam int MODE_W  = 3;
    localparam int STAT_W  = 3;
    localparam int DATA_W  = 32;
    localparam int CMD_W   = 3;

    localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

    localparam logic [MODE_W-1:0] MODE_READ   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SWAP   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd5;
    localparam logic [MODE_W-1:0] MODE_POP    = 3'd6;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd7;

    localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
    localparam logic [STAT_W-1:0] ST_POS1  = 3'd1;
    localparam logic [STAT_W-1:0] ST_POS2  = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL  = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY = 3'd4;

    localparam logic [CMD_W-1:0] CMD_HOLD       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SHIFT_UP   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SHIFT_DOWN = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SWAP       = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0] kind;
        logic [CNT_W-1:0] pos;
        logic [CNT_W-1:0] pos2;
        logic [CNT_W-1:0] cnt;
    } cell_cmd_t;

endpackage

>>> src/fcal_if.sv
// ----------------------------------------------------------------------------
// fcal_if - operation and result channels
// Valid/ready channels carrying one list operation or one result per beat.
// ----------------------------------------------------------------------------
interface fcal_op_if;
    logic                           valid;
    logic                           ready;
    logic [fcal_pkg::MODE_W-1:0]    mode;
    logic [fcal_pkg::CNT_W-1:0]     position;
    logic [fcal_pkg::POS2_W-1:0]    second_position;
    logic [fcal_pkg::DATA_W-1:0]    data_value;

    modport source (output valid, mode, position, second_position, data_value,
                    input ready);
    modport sink (input valid, mode, position, second_position, data_value,
                  output ready);
endinterface

interface fcal_res_if;
    logic                           valid;
    logic                           ready;
    logic [fcal_pkg::STAT_W-1:0]    status;
    logic [fcal_pkg::DATA_W-1:0]    read_value;
    logic [fcal_pkg::CNT_W-1:0]     element_count;

    modport source (output valid, status, read_value, element_count,
                    input ready);
    modport sink (input valid, status, read_value, element_count,
                  output ready);
endinterface

>>> src/fcal_cell.sv
// ----------------------------------------------------------------------------
// fcal_cell - one element slot of the list
// Holds one element and, on a broadcast command, loads new data, takes its
// left or right neighbor's value, or keeps its own.
// ----------------------------------------------------------------------------
module fcal_cell #(
    parameter int INDEX         = 0,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        en,
    input  fcal_pkg::cell_cmd_t         cmd,
    input  logic [ELEMENT_WIDTH-1:0]    value_a,
    input  logic [ELEMENT_WIDTH-1:0]    value_b,
    input  logic [ELEMENT_WIDTH-1:0]    left,
    input  logic [ELEMENT_WIDTH-1:0]    right,
    output logic [ELEMENT_WIDTH-1:0]    value
);

    logic [ELEMENT_WIDTH-1:0] val_reg;
    logic [ELEMENT_WIDTH-1:0] val_next;
    logic                     at_pos;
    logic                     at_pos2;

    assign at_pos  = (int'(cmd.pos) == INDEX);
    assign at_pos2 = (int'(cmd.pos2) == INDEX);

    always_comb
    begin
        val_next = val_reg;
        case (cmd.kind)
            fcal_pkg::CMD_WRITE:
            begin
                if (at_pos)
                    val_next = value_a;
            end
            fcal_pkg::CMD_SHIFT_UP:
            begin
                if (at_pos)
                    val_next = value_a;
                else if (INDEX > int'(cmd.pos) && INDEX <= int'(cmd.cnt))
                    val_next = left;
            end
            fcal_pkg::CMD_SHIFT_DOWN:
            begin
                if (INDEX >= int'(cmd.pos) && INDEX + 1 < int'(cmd.cnt))
                    val_next = right;
            end
            fcal_pkg::CMD_SWAP:
            begin
                if (at_pos)
                    val_next = value_a;
                else if (at_pos2)
                    val_next = value_b;
            end
            default:
            begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
            val_reg <= val_next;
    end

    assign value = val_reg;

endmodule

>>> src/fixed_capacity_array_list_top.sv
// ----------------------------------------------------------------------------
// fixed_capacity_array_list_top - ordered list engine on a chain of cells
// Takes one list operation per beat on the op channel and returns one result
// beat (status, read data, element count) on the res channel.
//
// Usage:
//   op:  mode, position, second_position, data_value. Accepted in idle only.
//   res: status, read_value, element_count, one beat per operation.
//   cfg_we / cfg_data write the capacity register; write it only while idle.
// Sequence: the operation is registered on acceptance, decided in the gather
//   cycle (pick the addressed elements) and applied in the apply cycle (all cells
//   shift or load at once), which also registers the result; a new operation is
//   accepted only after the apply cycle, back in idle.
// Reset: count clears to zero and capacity returns to 64; element contents
//   are not cleared, as only positions below count are ever read.
// Stall: while res is held off, the result register holds; a following
//   operation is accepted and waits in its apply cycle until the slot frees.
// ----------------------------------------------------------------------------
module fixed_capacity_array_list_top #(
    parameter int MAX_ELEMENTS  = 64,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    fcal_op_if.sink                         op,
    fcal_res_if.source                      res,
    input  logic                            cfg_we,
    input  logic [fcal_pkg::CNT_W-1:0]      cfg_data
);

    localparam int CW = fcal_pkg::CNT_W;
    localparam int EW = ELEMENT_WIDTH;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_GATHER = 2'd1;
    localparam logic [1:0] S_APPLY  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // operation held from the accepted beat
    logic [fcal_pkg::MODE_W-1:0]    op_mode_reg;
    logic [CW-1:0]                  op_pos_reg;
    logic [fcal_pkg::POS2_W-1:0]    op_pos2_reg;
    logic [fcal_pkg::DATA_W-1:0]    op_data_reg;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] cap_reg;

    // decision made in the gather cycle
    logic [fcal_pkg::STAT_W-1:0]    stat_reg;
    logic [fcal_pkg::STAT_W-1:0]    stat_next;
    logic [fcal_pkg::DATA_W-1:0]    rdv_reg;
    logic [fcal_pkg::DATA_W-1:0]    rdv_next;
    logic [CW-1:0]                  cnt_new_reg;
    logic [CW-1:0]                  cnt_new_next;
    fcal_pkg::cell_cmd_t            cmd_reg;
    fcal_pkg::cell_cmd_t            cmd_next;
    logic [EW-1:0]                  va_reg;
    logic [EW-1:0]                  va_next;
    logic [EW-1:0]                  vb_reg;
    logic [EW-1:0]                  vb_next;

    logic                           res_valid_reg;
    logic [fcal_pkg::STAT_W-1:0]    res_status_reg;
    logic [fcal_pkg::DATA_W-1:0]    res_read_reg;
    logic [CW-1:0]                  res_count_reg;

    logic [EW-1:0] cell_val [MAX_ELEMENTS];
    logic [EW-1:0] pick_a;
    logic [EW-1:0] pick_b;
    logic [CW-1:0] pos2_ext;
    logic [CW-1:0] ins_pos;
    logic [CW-1:0] eff_cap;
    logic [CW-1:0] eff_cfg;
    logic          accept;
    logic          apply;

    function automatic logic [CW-1:0] eff_of(input logic [CW-1:0] cap);
        logic [CW-1:0] e;
        if (cap == '0)
            e = CW'(1);
        else if (int'(cap) > MAX_ELEMENTS)
            e = CW'(MAX_ELEMENTS);
        else
            e = cap;
        return e;
    endfunction

    assign eff_cap  = eff_of(cap_reg);
    assign eff_cfg  = eff_of(cfg_data);
    assign accept   = op.valid && op.ready;
    assign apply    = (state_reg == S_APPLY) && (!res_valid_reg || res.ready);
    assign op.ready = (state_reg == S_IDLE);
    assign pos2_ext = {1'b0, op_pos2_reg};

    // chain of element cells
    genvar g;
    generate
        for (g = 0; g < MAX_ELEMENTS; g++)
        begin : g_cell
            logic [EW-1:0] left_val;
            logic [EW-1:0] right_val;
            if (g == 0)
            begin : g_first
                assign left_val = '0;
            end
            else
            begin : g_mid_l
                assign left_val = cell_val[g-1];
            end
            if (g == MAX_ELEMENTS - 1)
            begin : g_last
                assign right_val = '0;
            end
            else
            begin : g_mid_r
                assign right_val = cell_val[g+1];
            end
            fcal_cell #(
                .INDEX         (g),
                .ELEMENT_WIDTH (EW)
            ) u_cell (
                .clk     (clk),
                .en      (apply),
                .cmd     (cmd_reg),
                .value_a (va_reg),
                .value_b (vb_reg),
                .left    (left_val),
                .right   (right_val),
                .value   (cell_val[g])
            );
        end
    endgenerate

    // pick the elements at the first and second position
    always_comb
    begin
        pick_a = '0;
        pick_b = '0;
        for (int i = 0; i < MAX_ELEMENTS; i++)
        begin
            if (int'(op_pos_reg) == i)
                pick_a = pick_a | cell_val[i];
            if (int'(pos2_ext) == i)
                pick_b = pick_b | cell_val[i];
        end
    end

    assign ins_pos = (op_mode_reg == fcal_pkg::MODE_PUSH) ? count_reg : op_pos_reg;

    // decide status, new count and the cell command
    always_comb
    begin
        stat_next     = fcal_pkg::ST_OK;
        rdv_next      = '0;
        cnt_new_next  = count_reg;
        cmd_next.kind = fcal_pkg::CMD_HOLD;
        cmd_next.pos  = op_pos_reg;
        cmd_next.pos2 = pos2_ext;
        cmd_next.cnt  = count_reg;
        va_next       = EW'(op_data_reg);
        vb_next       = pick_a;
        case (op_mode_reg)
            fcal_pkg::MODE_READ:
            begin
                if (op_pos_reg >= count_reg)
                    stat_next = fcal_pkg::ST_POS1;
                else
                    rdv_next = fcal_pkg::DATA_W'(pick_a);
            end
            fcal_pkg::MODE_WRITE:
            begin
                if (op_pos_reg >= count_reg)
                    stat_next = fcal_pkg::ST_POS1;
                else
                    cmd_next.kind = fcal_pkg::CMD_WRITE;
            end
            fcal_pkg::MODE_INSERT, fcal_pkg::MODE_PUSH:
            begin
                cmd_next.pos = ins_pos;
                if (ins_pos > count_reg)
                    stat_next = fcal_pkg::ST_POS1;
                else if (count_reg >= eff_cap)
                    stat_next = fcal_pkg::ST_FULL;
                else
                begin
                    cmd_next.kind = fcal_pkg::CMD_SHIFT_UP;
                    cnt_new_next  = count_reg + CW'(1);
                end
            end
            fcal_pkg::MODE_REMOVE:
            begin
                if (op_pos_reg >= count_reg)
                    stat_next = fcal_pkg::ST_POS1;
                else
                begin
                    cmd_next.kind = fcal_pkg::CMD_SHIFT_DOWN;
                    cnt_new_next  = count_reg - CW'(1);
                end
            end
            fcal_pkg::MODE_SWAP:
            begin
                va_next = pick_b;
                if (op_pos_reg >= count_reg)
                    stat_next = fcal_pkg::ST_POS1;
                else if (pos2_ext >= count_reg)
                    stat_next = fcal_pkg::ST_POS2;
                else
                    cmd_next.kind = fcal_pkg::CMD_SWAP;
            end
            fcal_pkg::MODE_POP:
            begin
                if (count_reg == '0)
                    stat_next = fcal_pkg::ST_EMPTY;
                else
                    cnt_new_next = count_reg - CW'(1);
            end
            default:
            begin
                cnt_new_next = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_GATHER;
            end
            S_GATHER:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (apply)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // count: commit on apply, clip on a capacity write
    always_comb
    begin
        count_next = count_reg;
        if (apply)
            count_next = cnt_new_reg;
        else if (cfg_we && count_reg > eff_cfg)
            count_next = eff_cfg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cap_reg       <= fcal_pkg::CAP_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_we)
                cap_reg <= cfg_data;
            if (apply)
                res_valid_reg <= 1'b1;
            else if (res.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_mode_reg <= op.mode;
            op_pos_reg  <= op.position;
            op_pos2_reg <= op.second_position;
            op_data_reg <= op.data_value;
        end
        if (state_reg == S_GATHER)
        begin
            stat_reg    <= stat_next;
            rdv_reg     <= rdv_next;
            cnt_new_reg <= cnt_new_next;
            cmd_reg     <= cmd_next;
            va_reg      <= va_next;
            vb_reg      <= vb_next;
        end
        else if (apply)
        begin
            // drop the command so the cells hold outside the apply cycle
            cmd_reg.kind <= fcal_pkg::CMD_HOLD;
        end
        if (apply)
        begin
            res_status_reg <= stat_reg;
            res_read_reg   <= rdv_reg;
            res_count_reg  <= cnt_new_reg;
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.status        = res_status_reg;
    assign res.read_value    = res_read_reg;
    assign res.element_count = res_count_reg;

endmodule
